// File: hdl/tiex_pkg.sv
// ----------------------------------------------------------------------------
// tiex_pkg
// Opcodes and field widths of the toy instruction set execute core.
// ----------------------------------------------------------------------------
package tiex_pkg;

    localparam int INSTR_W = 16;
    localparam int XLEN    = 32;
    localparam int PC_W    = 8;
    localparam int REG_W   = 4;
    localparam int NREGS   = 16;

    typedef enum logic [3:0] {
        OP_LOAD  = 4'hF,
        OP_STORE = 4'h1,
        OP_ADD   = 4'h2,
        OP_ADDI  = 4'h3,
        OP_BEQZ  = 4'h4,
        OP_BLTZ  = 4'h5,
        OP_READ  = 4'h6,
        OP_PRINT = 4'h7,
        OP_JUMP  = 4'h8,
        OP_SUB   = 4'h9,
        OP_STIND = 4'hA,
        OP_LDIND = 4'hB,
        OP_XOR   = 4'hC
    } t_opcode;

endpackage

// File: hdl/toy_isa_execute_core.sv
// ----------------------------------------------------------------------------
// toy_isa_execute_core
// Executes one 16-bit instruction per input beat against a register file,
// a program counter and a data memory.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry i_instr_word and i_read_value.
// Output channel: o_valid / i_stall carry one result beat per instruction:
// next fetch address, print flag and value, read-taken flag, halt flag.
// Throughput is one instruction per cycle while the output is not stalled. An
// accepted input beat passes through the execute stage and the memory / write
// back stage into the output register (register file read as the beat is
// accepted, then execute and data memory access, then write back).
// Register file and data memory are synchronous RAMs; operands
// are forwarded from the two write backs that the RAM read cannot see yet.
// Reset (synchronous, active low) clears the counter, the halt flag and the
// per-entry valid bits, so every register and memory word reads as zero
// until written. No clearing pass is needed; the block takes beats in the
// first cycle after reset.
// When the receiver stalls a valid output beat, the whole pipeline holds and
// o_stall rises in the same cycle; otherwise input beats are never stalled.
// An undefined opcode sets a sticky halt; later instructions still give a result beat but have no effect.
// ----------------------------------------------------------------------------
module toy_isa_execute_core
    import tiex_pkg::*;
#(
    parameter int DATA_DEPTH = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [INSTR_W-1:0]      i_instr_word,
    input  logic signed [XLEN-1:0]  i_read_value,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [PC_W-1:0]         o_next_pc,
    output logic                    o_print_valid,
    output logic signed [XLEN-1:0]  o_print_value,
    output logic                    o_read_taken,
    output logic                    o_halted
);

    localparam int AW = $clog2(DATA_DEPTH);
    localparam logic [11:0] DM_D0 = 12'(DATA_DEPTH);
    localparam logic [11:0] DM_D1 = 12'(DATA_DEPTH * 2);
    localparam logic [11:0] DM_D2 = 12'(DATA_DEPTH * 4);
    localparam logic [11:0] DM_D3 = 12'(DATA_DEPTH * 8);

    function automatic logic [AW-1:0] f_dm_addr(input logic [7:0] a);
        logic [11:0] v;
        v = {4'd0, a};
        if (v >= DM_D3) v = v - DM_D3;
        if (v >= DM_D2) v = v - DM_D2;
        if (v >= DM_D1) v = v - DM_D1;
        if (v >= DM_D0) v = v - DM_D0;
        return v[AW-1:0];
    endfunction

    // storage
    logic [XLEN-1:0] rf_mem [NREGS];
    logic [NREGS-1:0] r_rf_vld;
    logic [XLEN-1:0] dm_mem [DATA_DEPTH];
    logic [DATA_DEPTH-1:0] r_dm_vld;

    logic adv;

    // execute stage
    logic               r_s1_valid;
    logic [INSTR_W-1:0] r_s1_instr;
    logic [XLEN-1:0]    r_s1_rv;
    logic [XLEN-1:0]    r_rf_qr;
    logic [XLEN-1:0]    r_rf_qs;
    logic               r_rf_qrv;
    logic               r_rf_qsv;

    // memory / write back stage
    logic               r_s2_valid;
    logic               r_s2_we;
    logic               r_s2_ld;
    logic [REG_W-1:0]   r_s2_wsel;
    logic [XLEN-1:0]    r_s2_wdata;
    logic [PC_W-1:0]    r_s2_pc;
    logic               r_s2_pv;
    logic [XLEN-1:0]    r_s2_pval;
    logic               r_s2_rt;
    logic               r_s2_halt;
    logic [XLEN-1:0]    r_dm_q;
    logic               r_dm_qv;

    // last write back, not yet visible to a read issued with it
    logic               r_wb_we;
    logic [REG_W-1:0]   r_wb_sel;
    logic [XLEN-1:0]    r_wb_data;

    // architectural control state
    logic [PC_W-1:0]    r_pc;
    logic               r_halt;

    // output register
    logic               r_out_valid;
    logic [PC_W-1:0]    r_out_pc;
    logic               r_out_pv;
    logic [XLEN-1:0]    r_out_pval;
    logic               r_out_rt;
    logic               r_out_halt;

    logic [XLEN-1:0]    s2_wval;
    logic               s2_wr;
    logic [REG_W-1:0]   s1_r;
    logic [REG_W-1:0]   s1_s;
    logic [7:0]         s1_imm;
    logic [XLEN-1:0]    vr;
    logic [XLEN-1:0]    vs;

    logic               n_we;
    logic               n_ld;
    logic [REG_W-1:0]   n_wsel;
    logic [XLEN-1:0]    n_wdata;
    logic               n_dm_we;
    logic [AW-1:0]      n_dm_addr;
    logic [PC_W-1:0]    n_pc;
    logic               n_pv;
    logic [XLEN-1:0]    n_pval;
    logic               n_rt;
    logic               n_halt;
    logic [PC_W-1:0]    pc_t;

    function automatic logic [XLEN-1:0] f_fwd(
        input logic [REG_W-1:0] sel,
        input logic [XLEN-1:0]  raw,
        input logic             raw_vld,
        input logic             s2_hit_en,
        input logic [REG_W-1:0] s2_sel,
        input logic [XLEN-1:0]  s2_val,
        input logic             wb_en,
        input logic [REG_W-1:0] wb_sel,
        input logic [XLEN-1:0]  wb_val
    );
        logic [XLEN-1:0] v;
        if (s2_hit_en && s2_sel == sel) begin
            v = s2_val;
        end else if (wb_en && wb_sel == sel) begin
            v = wb_val;
        end else begin
            v = raw_vld ? raw : '0;
        end
        return v;
    endfunction

    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;

    assign s2_wval = r_s2_ld ? (r_dm_qv ? r_dm_q : '0) : r_s2_wdata;
    assign s2_wr   = r_s2_valid && r_s2_we;

    assign s1_r   = r_s1_instr[3:0];
    assign s1_s   = r_s1_instr[7:4];
    assign s1_imm = r_s1_instr[11:4];

    assign vr = f_fwd(s1_r, r_rf_qr, r_rf_qrv, s2_wr, r_s2_wsel, s2_wval,
                      r_wb_we, r_wb_sel, r_wb_data);
    assign vs = f_fwd(s1_s, r_rf_qs, r_rf_qsv, s2_wr, r_s2_wsel, s2_wval,
                      r_wb_we, r_wb_sel, r_wb_data);

    always_comb begin
        n_we      = 1'b0;
        n_ld      = 1'b0;
        n_wsel    = s1_r;
        n_wdata   = '0;
        n_dm_we   = 1'b0;
        n_dm_addr = f_dm_addr(s1_imm);
        n_pv      = 1'b0;
        n_pval    = '0;
        n_rt      = 1'b0;
        n_halt    = r_halt;
        pc_t      = r_pc;
        n_pc      = r_pc;
        if (!r_halt) begin
            unique case (t_opcode'(r_s1_instr[15:12]))
                OP_LOAD: begin
                    n_we = 1'b1;
                    n_ld = 1'b1;
                end
                OP_STORE: begin
                    n_dm_we = 1'b1;
                end
                OP_ADD: begin
                    n_we    = 1'b1;
                    n_wsel  = s1_s;
                    n_wdata = vs + vr;
                end
                OP_ADDI: begin
                    n_we    = 1'b1;
                    n_wdata = vr + {{(XLEN-8){s1_imm[7]}}, s1_imm};
                end
                OP_BEQZ: begin
                    if (vr == '0) pc_t = r_pc + s1_imm;
                end
                OP_BLTZ: begin
                    if (vr[XLEN-1]) pc_t = r_pc + s1_imm;
                end
                OP_READ: begin
                    n_we    = 1'b1;
                    n_wdata = r_s1_rv;
                    n_rt    = 1'b1;
                end
                OP_PRINT: begin
                    n_pv   = 1'b1;
                    n_pval = vr;
                end
                OP_JUMP: begin
                    pc_t = s1_imm;
                end
                OP_SUB: begin
                    n_we    = 1'b1;
                    n_wsel  = s1_s;
                    n_wdata = vs - vr;
                end
                OP_STIND: begin
                    n_dm_we   = 1'b1;
                    n_dm_addr = f_dm_addr(vs[7:0]);
                end
                OP_LDIND: begin
                    n_we      = 1'b1;
                    n_ld      = 1'b1;
                    n_dm_addr = f_dm_addr(vs[7:0]);
                end
                OP_XOR: begin
                    n_we    = 1'b1;
                    n_wsel  = s1_s;
                    n_wdata = vs ^ vr;
                end
                default: begin
                    n_halt = 1'b1;
                end
            endcase
            if (!n_halt) n_pc = pc_t + PC_W'(1);
        end
    end

    // register file: two read ports, one write port
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rf_qr <= rf_mem[i_instr_word[3:0]];
            r_rf_qs <= rf_mem[i_instr_word[7:4]];
            if (s2_wr) rf_mem[r_s2_wsel] <= s2_wval;
        end
    end

    // data memory: one access per cycle while the pipeline advances
    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            if (n_dm_we) begin
                dm_mem[n_dm_addr] <= vr;
            end else begin
                r_dm_q <= dm_mem[n_dm_addr];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_instr <= i_instr_word;
            r_s1_rv    <= XLEN'(i_read_value);
            r_s2_ld    <= n_ld;
            r_s2_wsel  <= n_wsel;
            r_s2_wdata <= n_wdata;
            r_s2_pc    <= n_pc;
            r_s2_pv    <= n_pv;
            r_s2_pval  <= n_pval;
            r_s2_rt    <= n_rt;
            r_s2_halt  <= n_halt;
            r_wb_sel   <= r_s2_wsel;
            r_wb_data  <= s2_wval;
            r_out_pc   <= r_s2_pc;
            r_out_pv   <= r_s2_pv;
            r_out_pval <= r_s2_pval;
            r_out_rt   <= r_s2_rt;
            r_out_halt <= r_s2_halt;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s2_we     <= 1'b0;
            r_wb_we     <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_halt      <= 1'b0;
            r_rf_vld    <= '0;
            r_dm_vld    <= '0;
            r_rf_qrv    <= 1'b0;
            r_rf_qsv    <= 1'b0;
            r_dm_qv     <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_s2_we     <= n_we;
            r_wb_we     <= s2_wr;
            r_out_valid <= r_s2_valid;
            r_rf_qrv    <= r_rf_vld[i_instr_word[3:0]];
            r_rf_qsv    <= r_rf_vld[i_instr_word[7:4]];
            if (s2_wr) r_rf_vld[r_s2_wsel] <= 1'b1;
            if (r_s1_valid) begin
                r_pc   <= n_pc;
                r_halt <= n_halt;
                if (n_dm_we) begin
                    r_dm_vld[n_dm_addr] <= 1'b1;
                end else begin
                    r_dm_qv <= r_dm_vld[n_dm_addr];
                end
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_next_pc     = r_out_pc;
    assign o_print_valid = r_out_pv;
    assign o_print_value = signed'(r_out_pval);
    assign o_read_taken  = r_out_rt;
    assign o_halted      = r_out_halt;

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");

    a_print_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_print_valid && o_read_taken))
        else $error("print and read in one beat");

    a_halted_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_halted) |-> (!o_print_valid && !o_read_taken))
        else $error("halted beat carries side effects");

    a_halted_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_halted && !i_stall) |=>
            (!o_valid || (o_halted && $stable(o_next_pc))))
        else $error("pc moved after halt");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for toy_isa_execute_core. A directed table runs first:
// register, memory and branch extremes, some rows with hand-computed results
// after reset. A long random stream of legal instructions follows. An undefined
// opcode then halts the core, and the instructions after it must be ignored.
// Every result beat is compared against the hand-computed result of its row, if
// it has one, else against an in-bench instruction-set model. Both channels see
// random idle and stall bursts. The tail of the run has none.
// ----------------------------------------------------------------------------
module tb_top
    import tiex_pkg::*;
();

    localparam int DEPTH      = 256;
    localparam int NDIR       = 22;
    localparam int NRAND      = 1250;
    localparam int CYCLE_CAP  = 200000;

    typedef struct packed {
        logic [PC_W-1:0] pc;
        logic            pv;
        logic [XLEN-1:0] pval;
        logic            rt;
        logic            halt;
    } t_exec_result;

    typedef struct packed {
        logic [INSTR_W-1:0] word;
        logic [XLEN-1:0]    rval;
        logic               typed;
        t_exec_result       want;
    } t_stim_row;

    localparam t_opcode LEGAL_OPS [13] = '{
        OP_LOAD, OP_STORE, OP_ADD, OP_ADDI, OP_BEQZ, OP_BLTZ, OP_READ,
        OP_PRINT, OP_JUMP, OP_SUB, OP_STIND, OP_LDIND, OP_XOR
    };

    localparam t_stim_row DIR_TAB [NDIR] = '{
        '{16'h7000, 32'h0000_0000, 1'b1, '{8'd1, 1'b1, 32'h0000_0000, 1'b0, 1'b0}},
        '{16'h600F, 32'h7FFF_FFFF, 1'b1, '{8'd2, 1'b0, 32'h0000_0000, 1'b1, 1'b0}},
        '{16'h6001, 32'h8000_0000, 1'b1, '{8'd3, 1'b0, 32'h0000_0000, 1'b1, 1'b0}},
        '{16'h7001, 32'h0000_0000, 1'b1, '{8'd4, 1'b1, 32'h8000_0000, 1'b0, 1'b0}},
        '{16'h37F2, 32'hFFFF_FFFF, 1'b1, '{8'd5, 1'b0, 32'h0000_0000, 1'b0, 1'b0}},
        '{16'h3802, 32'h0000_0000, 1'b0, '0},
        '{16'h20F1, 32'h0000_0000, 1'b0, '0},
        '{16'h9021, 32'h0000_0000, 1'b0, '0},
        '{16'hC0F2, 32'h0000_0000, 1'b0, '0},
        '{16'h17FF, 32'h0000_0000, 1'b0, '0},
        '{16'h180F, 32'h0000_0000, 1'b0, '0},
        '{16'hF7F3, 32'h0000_0000, 1'b0, '0},
        '{16'hA0F1, 32'h0000_0000, 1'b0, '0},
        '{16'hB0F4, 32'h0000_0000, 1'b0, '0},
        '{16'h4805, 32'h0000_0000, 1'b0, '0},
        '{16'h47F1, 32'h0000_0000, 1'b0, '0},
        '{16'h57F1, 32'h0000_0000, 1'b0, '0},
        '{16'h5800, 32'h0000_0000, 1'b0, '0},
        '{16'h8FF0, 32'h0000_0000, 1'b1, '{8'd0, 1'b0, 32'h0000_0000, 1'b0, 1'b0}},
        '{16'h87F0, 32'h0000_0000, 1'b1, '{8'd128, 1'b0, 32'h0000_0000, 1'b0, 1'b0}},
        '{16'h700F, 32'h0000_0000, 1'b0, '0},
        '{16'hB0E6, 32'h0000_0000, 1'b0, '0}
    };

    localparam logic [INSTR_W-1:0] HALT_TAIL [6] = '{
        16'hD5A3, 16'h0FFF, 16'hE000, 16'h6003, 16'h7001, 16'h8010
    };

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_valid       = 1'b0;
    logic                   o_stall;
    logic [INSTR_W-1:0]     i_instr_word  = '0;
    logic signed [XLEN-1:0] i_read_value  = '0;
    logic                   o_valid;
    logic                   i_stall       = 1'b0;
    logic [PC_W-1:0]        o_next_pc;
    logic                   o_print_valid;
    logic signed [XLEN-1:0] o_print_value;
    logic                   o_read_taken;
    logic                   o_halted;

    logic                   row_typed     = 1'b0;
    t_exec_result           row_want      = '0;

    logic [XLEN-1:0]        gpr [NREGS];
    logic [XLEN-1:0]        dmem [DEPTH];
    logic [PC_W-1:0]        pc_q;
    logic                   halt_q;

    t_exec_result           expected_beats [$];
    t_exec_result           pred_beat;
    t_exec_result           want_beat;
    t_exec_result           got_beat;
    int                     fail_count    = 0;
    int                     stall_left    = 0;
    bit                     idle_on       = 1'b1;

    toy_isa_execute_core #(
        .DATA_DEPTH(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_instr_word  (i_instr_word),
        .i_read_value  (i_read_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_next_pc     (o_next_pc),
        .o_print_valid (o_print_valid),
        .o_print_value (o_print_value),
        .o_read_taken  (o_read_taken),
        .o_halted      (o_halted)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int data_addr(input logic [XLEN-1:0] a);
        return int'(a[7:0]) % DEPTH;
    endfunction

    function automatic t_exec_result execute_instr(input logic [INSTR_W-1:0] w,
                                                   input logic [XLEN-1:0] rv);
        t_opcode         op;
        logic [XLEN-1:0] imm;
        logic [3:0]      r;
        logic [3:0]      s;
        logic [PC_W-1:0] npc;
        t_exec_result    res;
        op  = t_opcode'(w[15:12]);
        imm = {{24{w[11]}}, w[11:4]};
        r   = w[3:0];
        s   = w[7:4];
        res = '0;
        if (!halt_q) begin
            npc = pc_q;
            case (op)
                OP_LOAD:  gpr[r] = dmem[data_addr(imm)];
                OP_STORE: dmem[data_addr(imm)] = gpr[r];
                OP_ADD:   gpr[s] = gpr[s] + gpr[r];
                OP_ADDI:  gpr[r] = gpr[r] + imm;
                OP_BEQZ:  if (gpr[r] == '0) npc = pc_q + imm[7:0];
                OP_BLTZ:  if (gpr[r][XLEN-1]) npc = pc_q + imm[7:0];
                OP_READ: begin
                    gpr[r] = rv;
                    res.rt = 1'b1;
                end
                OP_PRINT: begin
                    res.pv   = 1'b1;
                    res.pval = gpr[r];
                end
                OP_JUMP:  npc = imm[7:0];
                OP_SUB:   gpr[s] = gpr[s] - gpr[r];
                OP_STIND: dmem[data_addr(gpr[s])] = gpr[r];
                OP_LDIND: gpr[r] = dmem[data_addr(gpr[s])];
                OP_XOR:   gpr[s] = gpr[s] ^ gpr[r];
                default:  halt_q = 1'b1;
            endcase
            if (!halt_q) pc_q = npc + 8'd1;
        end
        res.pc   = pc_q;
        res.halt = halt_q;
        return res;
    endfunction

    task automatic send_beat(input logic [INSTR_W-1:0] w, input logic [XLEN-1:0] rv,
                             input logic typed, input t_exec_result want);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_instr_word <= w;
        i_read_value <= rv;
        row_typed    <= typed;
        row_want     <= want;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if (i_rst_n && idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                pred_beat = execute_instr(i_instr_word, i_read_value);
                expected_beats.push_back(row_typed ? row_want : pred_beat);
            end
            if (o_valid && !i_stall) begin
                got_beat = '{o_next_pc, o_print_valid, o_print_value, o_read_taken, o_halted};
                if (expected_beats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: result beat with nothing expected, pc=%0d",
                                 o_next_pc);
                end else begin
                    want_beat = expected_beats.pop_front();
                    if (got_beat.pc !== want_beat.pc || got_beat.pv !== want_beat.pv ||
                        got_beat.pval !== want_beat.pval || got_beat.rt !== want_beat.rt ||
                        got_beat.halt !== want_beat.halt) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $write("mismatch: want pc=%0d pv=%0d pval=%h rt=%0d halt=%0d,",
                                   want_beat.pc, want_beat.pv, want_beat.pval,
                                   want_beat.rt, want_beat.halt);
                            $display(" got pc=%0d pv=%0d pval=%h rt=%0d halt=%0d",
                                     got_beat.pc, got_beat.pv, got_beat.pval,
                                     got_beat.rt, got_beat.halt);
                        end
                    end
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_CAP) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    initial begin
        t_opcode         op;
        logic [7:0]      imm8;
        logic [3:0]      r;
        logic [XLEN-1:0] rv;
        foreach (gpr[i]) gpr[i] = '0;
        foreach (dmem[i]) dmem[i] = '0;
        pc_q   = '0;
        halt_q = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int n = 0; n < NDIR; n++)
            send_beat(DIR_TAB[n].word, DIR_TAB[n].rval, DIR_TAB[n].typed, DIR_TAB[n].want);

        for (int n = 0; n < NRAND; n++) begin
            if (n % 50 == 0)
                idle_on = (n < NRAND - 100) && ($urandom_range(0, 3) != 0);
            op   = LEGAL_OPS[$urandom_range(0, 12)];
            imm8 = 8'($urandom_range(0, 255));
            r    = 4'($urandom_range(0, 15));
            if ($urandom_range(0, 1) == 1) begin
                r[3:2]    = 2'b00;
                imm8[3:2] = 2'b00;
            end
            case ($urandom_range(0, 3))
                0:       rv = '0;
                1:       rv = 32'($urandom_range(0, 15)) - 32'd8;
                default: rv = $urandom;
            endcase
            send_beat({op, imm8, r}, rv, 1'b0, '0);
        end

        foreach (HALT_TAIL[i])
            send_beat(HALT_TAIL[i], $urandom, 1'b0, '0);

        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
